// ----- sv/float_argsort_engine_macros.svh -----
// assertion macros used by the argsort engine module
`ifndef FLOAT_ARGSORT_ENGINE_MACROS_SVH
`define FLOAT_ARGSORT_ENGINE_MACROS_SVH

// condition implies consequence in the same cycle
`define FAE_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("fae assertion failed");

// condition implies consequence in the next cycle
`define FAE_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("fae assertion failed");

`endif

// ----- sv/fae_pkg.sv -----
// types, constants and key functions of the argsort engine
package fae_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 4;

  // contents of one cell of the insertion chain
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] key;
    logic [POS_W-1:0] pos;
  } cell_data_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic insert;
    logic drain;
    logic asc;
  } cell_ctrl_t;

  // load / drain phase, one-hot
  typedef enum logic [1:0] {
    PH_LOAD  = 2'b01,
    PH_DRAIN = 2'b10
  } phase_t;

  // float bits to unsigned order key, both zeros folded together
  function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] bits);
    logic [VAL_W-1:0] b;
    b = (bits[VAL_W-2:0] == '0) ? '0 : bits;
    if (b[VAL_W-1]) begin
      return ~b;
    end
    return {1'b1, b[VAL_W-2:0]};
  endfunction

  // strict ordering, so equal keys keep input order
  function automatic logic goes_before(input logic [VAL_W-1:0] ka,
                                       input logic [VAL_W-1:0] kb,
                                       input logic asc);
    return asc ? (ka < kb) : (ka > kb);
  endfunction

endpackage

// ----- sv/fae_in_if.sv -----
// input channel: one float value per item with set framing flags
interface fae_in_if;
  logic                       valid;
  logic                       ready;
  logic [fae_pkg::VAL_W-1:0]  value_bits;
  logic                       ascending;
  logic                       last_value;

  modport source (output valid, value_bits, ascending, last_value, input ready);
  modport sink   (input valid, value_bits, ascending, last_value, output ready);
endinterface

// ----- sv/fae_out_if.sv -----
// output channel: one sorted input position per item
interface fae_out_if;
  logic                       valid;
  logic                       ready;
  logic [fae_pkg::POS_W-1:0]  position;
  logic                       last_rank;

  modport source (output valid, position, last_rank, input ready);
  modport sink   (input valid, position, last_rank, output ready);
endinterface

// ----- sv/fae_cell.sv -----
// one cell of the sorted insertion chain
module fae_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  fae_pkg::cell_ctrl_t       ctrl,
  input  logic [fae_pkg::VAL_W-1:0] new_key,
  input  logic [fae_pkg::POS_W-1:0] new_pos,
  input  logic                      prev_take,
  input  fae_pkg::cell_data_t       prev_data,
  input  fae_pkg::cell_data_t       next_data,
  output logic                      take,
  output fae_pkg::cell_data_t       data
);

  fae_pkg::cell_data_t data_next;

  // new key lands here or further up the chain
  always_comb begin
    take = !data.valid || fae_pkg::goes_before(new_key, data.key, ctrl.asc);
  end

  // hold, shift toward the tail on insert, or toward the head on drain
  always_comb begin
    data_next = data;
    if (ctrl.drain) begin
      data_next = next_data;
    end else if (ctrl.insert && take) begin
      if (prev_take) begin
        data_next = prev_data;
      end else begin
        data_next = '{valid: 1'b1, key: new_key, pos: new_pos};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data.valid <= 1'b0;
    end else begin
      data <= data_next;
    end
  end

endmodule

// ----- sv/float_argsort_engine.sv -----
// argsort engine for single-precision floats, built on an insertion chain
//
// Usage: a set of float values enters on items_in, one value per item. The
// ascending flag of the first item of a set picks the order (1 ascending,
// 0 descending); last_value marks the final item. Values past MAX_ITEMS are
// dropped, but a dropped item's last_value still ends the set.
// Once the set is complete, ranks_out gives the 0-based input position of
// each value in sorted order, one item per rank, with last_rank on the final
// one. Equal values (+0 and -0 included) keep their input order.
// Throughput: while loading, one value per cycle; each value is placed into
// the sorted chain of cells in the cycle it is accepted. The first rank is
// offered the cycle after the last value is accepted, and the chain drains
// one rank per cycle while ranks_out is ready. items_in is not ready during
// the drain.
// A stall on ranks_out freezes the chain; nothing is lost or repeated.
// Reset (rst, synchronous) empties the chain and returns to loading.
module float_argsort_engine #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic          clk,
  input  logic          rst,
  fae_in_if.sink        items_in,
  fae_out_if.source     ranks_out
);

  `include "float_argsort_engine_macros.svh"

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  fae_pkg::phase_t             phase;
  logic [CNT_W-1:0]            count;
  logic                        order_asc;
  fae_pkg::cell_ctrl_t         ctrl;
  fae_pkg::cell_data_t         cell_q [MAX_ITEMS];
  logic                        take_v [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]        valid_vec;
  logic [fae_pkg::VAL_W-1:0]   new_key;
  logic                        in_fire;
  logic                        out_fire;
  logic                        room;

  // handshakes
  assign items_in.ready = (phase == fae_pkg::PH_LOAD);
  assign in_fire        = items_in.valid && items_in.ready;
  assign ranks_out.valid     = (phase == fae_pkg::PH_DRAIN) && cell_q[0].valid;
  assign ranks_out.position  = cell_q[0].pos;
  assign ranks_out.last_rank = !cell_q[1].valid;
  assign out_fire       = ranks_out.valid && ranks_out.ready;

  // chain controls
  assign room    = (count < CNT_W'(MAX_ITEMS));
  assign new_key = fae_pkg::order_key(items_in.value_bits);
  assign ctrl    = '{insert: in_fire && room, drain: out_fire, asc: order_asc};

  // cell row
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    fae_pkg::cell_data_t prev_d;
    fae_pkg::cell_data_t next_d;
    logic                prev_t;

    if (i == 0) begin : g_head
      assign prev_d = '0;
      assign prev_t = 1'b0;
    end else begin : g_body
      assign prev_d = cell_q[i-1];
      assign prev_t = take_v[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_d = '0;
    end else begin : g_inner
      assign next_d = cell_q[i+1];
    end

    fae_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_key   (new_key),
      .new_pos   (fae_pkg::POS_W'(count)),
      .prev_take (prev_t),
      .prev_data (prev_d),
      .next_data (next_d),
      .take      (take_v[i]),
      .data      (cell_q[i])
    );

    assign valid_vec[i] = cell_q[i].valid;
  end

  // set framing and phase control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= fae_pkg::PH_LOAD;
      count     <= '0;
      order_asc <= 1'b0;
    end else begin
      case (phase)
        fae_pkg::PH_LOAD: begin
          if (in_fire) begin
            if (count == '0) begin
              order_asc <= items_in.ascending;
            end
            if (items_in.last_value) begin
              count <= '0;
              phase <= fae_pkg::PH_DRAIN;
            end else if (room) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        fae_pkg::PH_DRAIN: begin
          if (out_fire && ranks_out.last_rank) begin
            phase <= fae_pkg::PH_LOAD;
          end
        end
        default: begin
          phase <= fae_pkg::PH_LOAD;
        end
      endcase
    end
  end

  // checks
  `FAE_ASSERT_NOW(a_drain_has_head, clk, rst,
                  phase == fae_pkg::PH_DRAIN, cell_q[0].valid)
  `FAE_ASSERT_NOW(a_load_count_matches, clk, rst,
                  phase == fae_pkg::PH_LOAD, $countones(valid_vec) == int'(count))
  `FAE_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_ITEMS))
  `FAE_ASSERT_NEXT(a_final_rank_empties, clk, rst,
                   out_fire && ranks_out.last_rank,
                   phase == fae_pkg::PH_LOAD && valid_vec == '0)
  `FAE_ASSERT_NEXT(a_last_starts_drain, clk, rst,
                   in_fire && items_in.last_value,
                   phase == fae_pkg::PH_DRAIN && count == '0)

endmodule
